@@ rtl/core/encoder_speed_p_control_pwm_top_defines.svh @@
// Assertion macros for the encoder speed controller.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef ENCODER_SPEED_P_CONTROL_PWM_TOP_DEFINES_SVH
`define ENCODER_SPEED_P_CONTROL_PWM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ESPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ESPPC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ESPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ESPPC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/esppc_pkg.sv @@
// Package for the encoder speed controller: widths, reset values, register
// indexes and the structs passed between the front, queue and back. No dependencies.
`timescale 1ns / 1ps

package esppc_pkg;

    localparam int AVG_WINDOWS_DEF   = 5;
    localparam int POSITION_BITS_DEF = 32;

    localparam int SUM_W      = 24;
    localparam int SPEED_W    = 16;
    localparam int DUTY_W     = 8;
    localparam int POS_OUT_W  = 32;
    localparam int TICK_W     = 20;
    localparam int GAIN_W     = 8;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int PROD_W     = ERR_W + GAIN_W + 1;
    localparam int SCALED_W   = SPEED_W + SCALE_W;

    localparam int QUEUE_DEPTH = 2;

    localparam int SUM_MAX   = 8388607;
    localparam int SUM_MIN   = -8388608;
    localparam int SPEED_MAX = 32767;
    localparam int SPEED_MIN = -32768;

    localparam logic signed [SPEED_W-1:0] SETPOINT_RST = 16'sd0;
    localparam logic [GAIN_W-1:0]         GAIN_KP_RST  = 8'd80;
    localparam logic [TICK_W-1:0]         WINDOW_RST   = 20'd2000;
    localparam logic [SCALE_W-1:0]        SCALE_RST    = 16'd256;
    localparam logic [DUTY_W-1:0]         PERIOD_RST   = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_KP  = 3'd1,
        CFG_WINDOW   = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_PERIOD   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SPEED_W-1:0] setpoint;
        logic [GAIN_W-1:0]         gain_kp;
        logic [TICK_W-1:0]         window_ticks;
        logic [SCALE_W-1:0]        duty_scale;
        logic [DUTY_W-1:0]         pwm_period;
    } t_cfg;

    // One classified tick travelling from front to back.
    typedef struct packed {
        logic                    update;
        logic                    enable;
        logic signed [SUM_W-1:0] sum;
        logic [POS_OUT_W-1:0]    position;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SPEED,
        BK_MUL,
        BK_DRIVE,
        BK_SCALE,
        BK_DUTY,
        BK_EMIT
    } t_bk_state;

endpackage

@@ rtl/core/esppc_ifs.sv @@
// Channel interfaces: input ticks, result items and configuration writes.
// Depends on esppc_pkg.
`timescale 1ns / 1ps

interface esppc_in_if;
    logic valid;
    logic ready;
    logic enc_a;
    logic enc_b;
    logic enable;
    modport source (output valid, enc_a, enc_b, enable, input ready);
    modport sink   (input valid, enc_a, enc_b, enable, output ready);
endinterface

interface esppc_out_if;
    import esppc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      pwm_out;
    logic                      direction;
    logic [DUTY_W-1:0]         duty_now;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [POS_OUT_W-1:0] position;
    logic                      speed_valid;
    modport source (output valid, pwm_out, direction, duty_now, measured_speed,
                    position, speed_valid, input ready);
    modport sink   (input valid, pwm_out, direction, duty_now, measured_speed,
                    position, speed_valid, output ready);
endinterface

interface esppc_cfg_if;
    import esppc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/core/esppc_front.sv @@
// Front end: takes ticks, tracks position, window timing and the window sum,
// and pushes one classified request per tick. Depends on esppc_pkg, esppc_ifs.
`timescale 1ns / 1ps

module esppc_front #(
    parameter int AVG_WINDOWS   = esppc_pkg::AVG_WINDOWS_DEF,
    parameter int POSITION_BITS = esppc_pkg::POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    esppc_in_if.sink              i_in,
    input  esppc_pkg::t_cfg       i_cfg,
    input  esppc_pkg::t_q_status  i_q,
    output logic                  o_push,
    output esppc_pkg::t_cmd       o_cmd
);
    import esppc_pkg::*;

    localparam int WIN_W     = $clog2(AVG_WINDOWS + 1);
    localparam int EXT_W     = (POSITION_BITS > SUM_W ? POSITION_BITS : SUM_W) + 1;
    localparam int POS_EXT_W = POSITION_BITS > POS_OUT_W ? POSITION_BITS : POS_OUT_W;

    logic                        r_prev_a;
    logic [POSITION_BITS-1:0]    r_count;
    logic [POSITION_BITS-1:0]    r_wdelta;   // count change since window start
    logic [TICK_W-1:0]           r_tick;
    logic [WIN_W-1:0]            r_win;
    logic signed [SUM_W-1:0]     r_sum;

    logic                        accept;
    logic                        rise_a;
    logic [POSITION_BITS-1:0]    n_count;
    logic [POSITION_BITS-1:0]    n_wdelta;
    logic signed [POSITION_BITS-1:0] s_delta;
    logic [TICK_W-1:0]           wt;
    logic                        win_end;
    logic signed [EXT_W:0]       sum_ext;
    logic signed [SUM_W-1:0]     sat_sum;
    logic [WIN_W:0]              win_next;
    logic                        win_last;

    assign i_in.ready = !i_q.full;
    assign accept     = i_in.valid && i_in.ready;
    assign rise_a     = i_in.enc_a && !r_prev_a;

    always_comb begin
        n_count  = r_count;
        n_wdelta = r_wdelta;
        if (rise_a) begin
            if (i_in.enc_b) begin
                n_count  = r_count + POSITION_BITS'(1);
                n_wdelta = r_wdelta + POSITION_BITS'(1);
            end else begin
                n_count  = r_count - POSITION_BITS'(1);
                n_wdelta = r_wdelta - POSITION_BITS'(1);
            end
        end
    end

    // a window length of zero behaves as one
    assign wt      = (i_cfg.window_ticks == '0) ? TICK_W'(1) : i_cfg.window_ticks;
    assign win_end = ({1'b0, r_tick} + (TICK_W + 1)'(1)) >= {1'b0, wt};

    assign s_delta = n_wdelta;
    assign sum_ext = (EXT_W + 1)'(s_delta) + (EXT_W + 1)'(r_sum);

    always_comb begin
        if (sum_ext > SUM_MAX) begin
            sat_sum = SUM_W'(SUM_MAX);
        end else if (sum_ext < SUM_MIN) begin
            sat_sum = SUM_W'(SUM_MIN);
        end else begin
            sat_sum = SUM_W'(sum_ext);
        end
    end

    assign win_next = {1'b0, r_win} + (WIN_W + 1)'(1);
    assign win_last = win_next >= (WIN_W + 1)'(AVG_WINDOWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_count  <= '0;
            r_wdelta <= '0;
            r_tick   <= '0;
            r_win    <= '0;
            r_sum    <= '0;
        end else if (accept) begin
            r_prev_a <= i_in.enc_a;
            r_count  <= n_count;
            if (win_end) begin
                r_tick   <= '0;
                r_wdelta <= '0;
                if (win_last) begin
                    r_sum <= '0;
                    r_win <= '0;
                end else begin
                    r_sum <= sat_sum;
                    r_win <= WIN_W'(win_next);
                end
            end else begin
                r_tick   <= r_tick + TICK_W'(1);
                r_wdelta <= n_wdelta;
            end
        end
    end

    assign o_push          = accept;
    assign o_cmd.update    = win_end && win_last;
    assign o_cmd.enable    = i_in.enable;
    assign o_cmd.sum       = sat_sum;
    assign o_cmd.position  = POS_OUT_W'(POS_EXT_W'(n_count));

endmodule

@@ rtl/core/esppc_queue.sv @@
// Short request queue between front and back ends.
// Depends on esppc_pkg.
`timescale 1ns / 1ps

module esppc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  esppc_pkg::t_cmd       i_cmd,
    input  logic                  i_pop,
    output esppc_pkg::t_cmd       o_cmd,
    output esppc_pkg::t_q_status  o_status
);
    import esppc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_status.full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_cnt == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/esppc_back.sv @@
// Back end: speed average (reciprocal multiply), P control, duty scaling,
// PWM phase and the result register. Depends on esppc_pkg, esppc_ifs.
`timescale 1ns / 1ps

module esppc_back #(
    parameter int AVG_WINDOWS = esppc_pkg::AVG_WINDOWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  esppc_pkg::t_cfg       i_cfg,
    input  esppc_pkg::t_cmd       i_cmd,
    input  esppc_pkg::t_q_status  i_q,
    output logic                  o_pop,
    esppc_out_if.source           o_res
);
    import esppc_pkg::*;

    // |sum| / AVG_WINDOWS as (|sum| * ceil(2^S / AVG_WINDOWS)) >> S; with S three bits
    // above the sum width this is exact for every magnitude up to 2^SUM_W - 1
    localparam int     DIV_SHIFT  = SUM_W + 3;
    localparam int     DIV_MUL_W  = DIV_SHIFT + 1;
    localparam int     DIV_PROD_W = SUM_W + DIV_MUL_W;
    localparam longint DIV_MUL_L  = ((longint'(1) << DIV_SHIFT) + longint'(AVG_WINDOWS) - 1)
                                    / longint'(AVG_WINDOWS);
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);

    t_bk_state                 r_state, n_state;
    t_cmd                      r_cmd;
    logic [SUM_W-1:0]          r_quo;
    logic                      r_neg;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SPEED_W-1:0]        r_mag;
    logic                      r_dir;
    logic [SCALED_W-1:0]       r_scaled;
    logic [DUTY_W-1:0]         r_duty;
    logic [DUTY_W-1:0]         r_phase;

    logic                      r_out_valid;
    logic                      r_o_pwm;
    logic                      r_o_dir;
    logic [DUTY_W-1:0]         r_o_duty;
    logic signed [SPEED_W-1:0] r_o_speed;
    logic [POS_OUT_W-1:0]      r_o_pos;
    logic                      r_o_sv;

    logic                      out_free;
    logic                      load;
    logic                      div_start;
    t_cmd                      emit_cmd;

    logic [DIV_PROD_W-1:0]     div_prod;
    logic signed [SPEED_W-1:0] speed_sat;
    logic signed [ERR_W-1:0]   err;
    logic signed [PROD_W:0]    drv_ext;
    logic signed [SPEED_W-1:0] drive;
    logic [DUTY_W:0]           phase_nxt;
    logic [SCALED_W-9:0]       duty_raw;

    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load      = 1'b0;
        div_start = 1'b0;
        emit_cmd  = r_cmd;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q.empty) begin
                    if (i_cmd.update) begin
                        o_pop     = 1'b1;
                        div_start = 1'b1;
                        n_state   = BK_DIV;
                    end else if (out_free) begin
                        // plain tick: result goes straight out
                        o_pop    = 1'b1;
                        load     = 1'b1;
                        emit_cmd = i_cmd;
                    end
                end
            end
            BK_DIV:   n_state = BK_SPEED;
            BK_SPEED: n_state = BK_MUL;
            BK_MUL:   n_state = BK_DRIVE;
            BK_DRIVE: n_state = BK_SCALE;
            BK_SCALE: n_state = BK_DUTY;
            BK_DUTY:  n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign div_prod = DIV_PROD_W'(r_quo) * DIV_PROD_W'(DIV_MUL);

    always_comb begin
        if (!r_neg) begin
            speed_sat = (r_quo > SUM_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                   : SPEED_W'(r_quo);
        end else begin
            speed_sat = (r_quo > SUM_W'(-SPEED_MIN)) ? SPEED_W'(SPEED_MIN)
                                                    : -SPEED_W'(r_quo);
        end
    end

    assign err     = ERR_W'(i_cfg.setpoint) - ERR_W'(r_speed);
    assign drv_ext = (PROD_W + 1)'(i_cfg.setpoint) + (PROD_W + 1)'(r_prod >>> 4);

    always_comb begin
        if (!r_cmd.enable) begin
            drive = '0;
        end else if (drv_ext > SPEED_MAX) begin
            drive = SPEED_W'(SPEED_MAX);
        end else if (drv_ext < SPEED_MIN) begin
            drive = SPEED_W'(SPEED_MIN);
        end else begin
            drive = SPEED_W'(drv_ext);
        end
    end

    assign duty_raw  = r_scaled[SCALED_W-1:8];
    assign phase_nxt = {1'b0, r_phase} + (DUTY_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_duty  <= '0;
            r_dir   <= 1'b0;
            r_phase <= '0;
        end else begin
            unique case (r_state)
                BK_SPEED: r_speed <= speed_sat;
                BK_DRIVE: r_dir   <= (drive > 0);
                BK_DUTY: begin
                    r_duty <= (duty_raw > (SCALED_W - 8)'(i_cfg.pwm_period))
                              ? i_cfg.pwm_period : DUTY_W'(duty_raw);
                end
                default: ;
            endcase
            if (load) begin
                r_phase <= (phase_nxt >= {1'b0, i_cfg.pwm_period}) ? '0
                                                                   : DUTY_W'(phase_nxt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_cmd <= i_cmd;
            r_neg <= i_cmd.sum[SUM_W-1];
            r_quo <= i_cmd.sum[SUM_W-1] ? SUM_W'(-i_cmd.sum) : SUM_W'(i_cmd.sum);
        end else if (r_state == BK_DIV) begin
            r_quo <= div_prod[DIV_SHIFT +: SUM_W];
        end
        if (r_state == BK_MUL) begin
            r_prod <= PROD_W'(err) * PROD_W'($signed({1'b0, i_cfg.gain_kp}));
        end
        if (r_state == BK_DRIVE) begin
            r_mag <= drive[SPEED_W-1] ? SPEED_W'(-drive) : SPEED_W'(drive);
        end
        if (r_state == BK_SCALE) begin
            r_scaled <= SCALED_W'(r_mag) * SCALED_W'(i_cfg.duty_scale);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_pwm   <= r_phase < r_duty;
            r_o_dir   <= r_dir;
            r_o_duty  <= r_duty;
            r_o_speed <= r_speed;
            r_o_pos   <= emit_cmd.position;
            r_o_sv    <= emit_cmd.update;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.pwm_out        = r_o_pwm;
    assign o_res.direction      = r_o_dir;
    assign o_res.duty_now       = r_o_duty;
    assign o_res.measured_speed = r_o_speed;
    assign o_res.position       = r_o_pos;
    assign o_res.speed_valid    = r_o_sv;

endmodule

@@ rtl/core/encoder_speed_p_control_pwm_top.sv @@
// Quadrature encoder speed controller with P control and PWM output.
// A plain tick passes through the queue and the result register; ticks are taken one per
// cycle between updates while the queue has room. A tick closing the averaging run takes
// the back end through divide, speed, gain, drive, scale, duty and emit before loading.
// The front keeps taking ticks into a 2-entry queue while the back works, until it is full.
// Reset (synchronous, active low) clears the control state and loads register defaults.
`timescale 1ns / 1ps
`include "encoder_speed_p_control_pwm_top_defines.svh"

module encoder_speed_p_control_pwm_top #(
    parameter int AVG_WINDOWS   = esppc_pkg::AVG_WINDOWS_DEF,
    parameter int POSITION_BITS = esppc_pkg::POSITION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    esppc_in_if.sink     i_in,
    esppc_out_if.source  o_res,
    esppc_cfg_if.sink    i_cfg
);
    import esppc_pkg::*;

    t_cfg      r_cfg;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_stat;
    logic      push;
    logic      pop;
    logic      res_fresh;
    logic      res_high;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint     <= SETPOINT_RST;
            r_cfg.gain_kp      <= GAIN_KP_RST;
            r_cfg.window_ticks <= WINDOW_RST;
            r_cfg.duty_scale   <= SCALE_RST;
            r_cfg.pwm_period   <= PERIOD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_SETPOINT: r_cfg.setpoint     <= i_cfg.wdata[SPEED_W-1:0];
                CFG_GAIN_KP:  r_cfg.gain_kp      <= i_cfg.wdata[GAIN_W-1:0];
                CFG_WINDOW:   r_cfg.window_ticks <= i_cfg.wdata[TICK_W-1:0];
                CFG_SCALE:    r_cfg.duty_scale   <= i_cfg.wdata[SCALE_W-1:0];
                CFG_PERIOD:   r_cfg.pwm_period   <= i_cfg.wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    esppc_front #(
        .AVG_WINDOWS   (AVG_WINDOWS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_q     (q_stat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    esppc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_stat)
    );

    esppc_back #(
        .AVG_WINDOWS (AVG_WINDOWS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (head_cmd),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    assign res_fresh = o_res.valid && o_res.speed_valid;
    assign res_high  = o_res.valid && o_res.pwm_out;

    // a fresh duty never exceeds the period in force
    `ESPPC_ASSERT_IMP(a_duty_cap, i_clk, i_rst_n, res_fresh, o_res.duty_now <= r_cfg.pwm_period)
    // PWM high needs a nonzero duty
    `ESPPC_ASSERT_IMP(a_pwm_duty, i_clk, i_rst_n, res_high, o_res.duty_now != '0)
    `ESPPC_ASSERT_NEVER(a_q_state, i_clk, i_rst_n, q_stat.full && q_stat.empty)

endmodule

@@ sim/encoder_speed_p_control_pwm_top_test.sv @@
// Self-checking bench for encoder_speed_p_control_pwm_top: table-driven directed ticks,
// then random quadrature walks under random register settings, all scored in order.
// Depends on esppc_pkg, esppc_ifs and the top level RTL.
`timescale 1ns / 1ps

module encoder_speed_p_control_pwm_top_test;
    import esppc_pkg::*;

    localparam int  AVG_N         = AVG_WINDOWS_DEF;
    localparam int  CYCLE_LIMIT   = 300000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  IDLE_PCT      = 14;
    localparam int  CALM_FIRST    = 150;
    localparam int  CALM_LAST     = 260;
    localparam int  HOLD_AT       = 330;
    localparam int  HOLD_CYCLES   = 90;
    localparam int  NUM_PHASES    = 8;
    localparam int  MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    typedef struct packed {
        logic                      pwm;
        logic                      dir;
        logic [DUTY_W-1:0]         duty;
        logic signed [SPEED_W-1:0] speed;
        logic [POS_OUT_W-1:0]      pos;
        logic                      fresh;
    } t_res;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    a, b, en;
        bit                    known;
        t_res                  want;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    esppc_in_if  in_if ();
    esppc_out_if res_if ();
    esppc_cfg_if cfg_if ();

    encoder_speed_p_control_pwm_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // controller copy: registers
    logic signed [SPEED_W-1:0] c_setpoint;
    logic [GAIN_W-1:0]         c_gain;
    logic [TICK_W-1:0]         c_window;
    logic [SCALE_W-1:0]        c_scale;
    logic [DUTY_W-1:0]         c_period;
    // controller copy: state
    bit                        m_prev_a;
    logic [POS_OUT_W-1:0]      m_count;
    logic [POS_OUT_W-1:0]      m_wstart;
    logic [TICK_W-1:0]         m_tick;
    int                        m_widx;
    longint                    m_sum;
    logic signed [SPEED_W-1:0] m_speed;
    logic [DUTY_W-1:0]         m_duty;
    bit                        m_dir;
    logic [DUTY_W-1:0]         m_phase;

    t_res  tick_outputs[$];
    t_step steps[$];
    int    n_ticks;
    int    n_results;
    int    n_errors;
    int    n_cycles;
    bit    ticking;
    int    enc_q;
    int    enc_dir;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void controller_reset();
        c_setpoint = SETPOINT_RST;
        c_gain     = GAIN_KP_RST;
        c_window   = WINDOW_RST;
        c_scale    = SCALE_RST;
        c_period   = PERIOD_RST;
        m_prev_a   = 1'b0;
        m_count    = '0;
        m_wstart   = '0;
        m_tick     = '0;
        m_widx     = 0;
        m_sum      = 0;
        m_speed    = '0;
        m_duty     = '0;
        m_dir      = 1'b0;
        m_phase    = '0;
    endfunction

    function automatic void controller_config(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SETPOINT: c_setpoint = data[SPEED_W-1:0];
            CFG_GAIN_KP:  c_gain     = data[GAIN_W-1:0];
            CFG_WINDOW:   c_window   = data[TICK_W-1:0];
            CFG_SCALE:    c_scale    = data[SCALE_W-1:0];
            CFG_PERIOD:   c_period   = data[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_res controller_tick(input bit a, input bit b, input bit en);
        t_res                 r;
        int                   wt;
        int                   nxt;
        logic [POS_OUT_W-1:0] diff;
        longint               sp;
        longint               drive;
        longint               mag;
        longint               dt;
        r.fresh = 1'b0;
        wt = (c_window == 0) ? 1 : int'(c_window);
        if (a && !m_prev_a)
            m_count = b ? m_count + 1 : m_count - 1;
        m_prev_a = a;
        if (int'(m_tick) + 1 >= wt) begin
            diff     = m_count - m_wstart;
            m_tick   = '0;
            m_wstart = m_count;
            m_sum    = clamp(m_sum + longint'($signed(diff)), SUM_MIN, SUM_MAX);
            m_widx   = (m_widx + 1) & 7;
            if (m_widx >= AVG_N) begin
                m_speed = SPEED_W'(clamp(m_sum / AVG_N, SPEED_MIN, SPEED_MAX));
                m_sum   = 0;
                m_widx  = 0;
                r.fresh = 1'b1;
                drive   = 0;
                if (en) begin
                    sp    = longint'(c_setpoint);
                    // >>> on a signed product floors, as the gain shift requires
                    drive = sp + (((sp - longint'(m_speed)) * longint'(c_gain)) >>> 4);
                    drive = clamp(drive, SPEED_MIN, SPEED_MAX);
                end
                mag = (drive < 0) ? -drive : drive;
                dt  = (mag * longint'(c_scale)) >>> 8;
                if (dt > longint'(c_period))
                    dt = longint'(c_period);
                m_duty = dt[DUTY_W-1:0];
                m_dir  = (drive > 0);
            end
        end else begin
            m_tick = m_tick + TICK_W'(1);
        end
        r.pwm   = (m_phase < m_duty);
        nxt     = int'(m_phase) + 1;
        m_phase = (nxt >= int'(c_period)) ? '0 : nxt[DUTY_W-1:0];
        r.dir   = m_dir;
        r.duty  = m_duty;
        r.speed = m_speed;
        r.pos   = m_count;
        return r;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        steps.push_back(s);
    endfunction

    function automatic void add_tick(input bit a, input bit b, input bit en);
        t_step s;
        s = '{default: '0};
        s.a  = a;
        s.b  = b;
        s.en = en;
        steps.push_back(s);
    endfunction

    // typed expectation; duty, speed and direction are still at their reset values
    function automatic void add_known(input bit a, input bit b, input bit en,
                                      input logic [POS_OUT_W-1:0] pos);
        t_step s;
        s = '{default: '0};
        s.a        = a;
        s.b        = b;
        s.en       = en;
        s.known    = 1'b1;
        s.want     = '0;
        s.want.pos = pos;
        steps.push_back(s);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (ticking) begin
            // registers change only with nothing in flight
            in_if.valid <= 1'b0;
            while (tick_outputs.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            ticking = 1'b0;
        end
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        controller_config(idx, data);
    endtask

    task automatic send_tick(input bit a, input bit b, input bit en, input bit known,
                             input t_res want);
        int   gaps;
        t_res r;
        gaps = 0;
        if (!ticking) begin
            cfg_if.valid <= 1'b0;
            ticking = 1'b1;
        end
        if (n_ticks < CALM_FIRST || n_ticks >= CALM_LAST)
            while ($urandom_range(99) < IDLE_PCT)
                gaps++;
        if (gaps > 0) begin
            in_if.valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.enc_a  <= a;
        in_if.enc_b  <= b;
        in_if.enable <= en;
        do @(posedge i_clk); while (!in_if.ready);
        r = controller_tick(a, b, en);
        tick_outputs.push_back(known ? want : r);
        n_ticks++;
    endtask

    // result side: random back-pressure, one long hold-off, in-order scoring
    initial begin : result_side
        int   hold_left;
        bit   hold_done;
        t_res want;
        t_res got;
        bit   calm;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.pwm   = res_if.pwm_out;
                got.dir   = res_if.direction;
                got.duty  = res_if.duty_now;
                got.speed = res_if.measured_speed;
                got.pos   = res_if.position;
                got.fresh = res_if.speed_valid;
                if (tick_outputs.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result %0d: pwm=%0b dir=%0b duty=%0d speed=%0d pos=%h vld=%0b",
                                 n_results, got.pwm, got.dir, got.duty, got.speed, got.pos,
                                 got.fresh);
                end else begin
                    want = tick_outputs.pop_front();
                    if (got.pwm !== want.pwm || got.dir !== want.dir ||
                        got.duty !== want.duty || got.speed !== want.speed ||
                        got.pos !== want.pos || got.fresh !== want.fresh) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("mismatch at result %0d", n_results);
                            $display("  exp pwm=%0b dir=%0b duty=%0d speed=%0d pos=%h vld=%0b",
                                     want.pwm, want.dir, want.duty, want.speed, want.pos,
                                     want.fresh);
                            $display("  got pwm=%0b dir=%0b duty=%0d speed=%0d pos=%h vld=%0b",
                                     got.pwm, got.dir, got.duty, got.speed, got.pos, got.fresh);
                        end
                    end
                end
                n_results++;
            end
            if (n_results == HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            calm = (n_results >= CALM_FIRST && n_results < CALM_LAST);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int   ph;
        int   i;
        int   n;
        int   sp;
        int   r;
        bit   a, b, en;
        int   en_pct;
        t_res none;
        none = '0;
        n_ticks   = 0;
        n_results = 0;
        n_errors  = 0;
        ticking   = 1'b1;
        enc_q     = 0;
        enc_dir   = 1;
        in_if.valid      <= 1'b0;
        in_if.enc_a      <= 1'b0;
        in_if.enc_b      <= 1'b0;
        in_if.enable     <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= CFG_SETPOINT;
        cfg_if.wdata     <= '0;
        i_rst_n          <= 1'b0;
        controller_reset();

        // reset values: edges on A move the count both ways and wrap below zero
        add_known(1'b0, 1'b0, 1'b1, 32'h0000_0000);
        add_known(1'b1, 1'b1, 1'b1, 32'h0000_0001);
        add_known(1'b0, 1'b1, 1'b1, 32'h0000_0001);
        add_known(1'b1, 1'b0, 1'b1, 32'h0000_0000);
        add_known(1'b1, 1'b1, 1'b1, 32'h0000_0000);
        add_known(1'b0, 1'b0, 1'b1, 32'h0000_0000);
        add_known(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
        add_known(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        // zero window, saturated drive and duty
        add_cfg(CFG_WINDOW, 20'd0);
        add_cfg(CFG_SETPOINT, 20'h07FFF);
        add_cfg(CFG_GAIN_KP, 20'd255);
        add_cfg(CFG_SCALE, 20'hFFFF);
        add_cfg(CFG_PERIOD, 20'd255);
        add_tick(1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 1'b1);
        // stale duty above a lowered period, enable ignored off the update tick
        add_cfg(CFG_PERIOD, 20'd3);
        add_tick(1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 1'b0);
        // most negative setpoint with zero gain, zero period
        add_cfg(CFG_SETPOINT, 20'h08000);
        add_cfg(CFG_GAIN_KP, 20'd0);
        add_cfg(CFG_PERIOD, 20'd0);
        add_cfg(CFG_UNUSED, 20'hFFFFF);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 1'b1);
        // update tick with enable low forces zero drive
        add_cfg(CFG_SETPOINT, 20'd100);
        add_cfg(CFG_PERIOD, 20'd1);
        add_cfg(CFG_SCALE, 20'd256);
        add_tick(1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            if (steps[k].is_cfg)
                write_reg(steps[k].idx, steps[k].data);
            else
                send_tick(steps[k].a, steps[k].b, steps[k].en, steps[k].known, steps[k].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(4))
                0: sp = SPEED_MIN;
                1: sp = SPEED_MAX;
                2: sp = int'($urandom_range(40)) - 20;
                default: sp = int'($urandom_range(16'hFFFF)) - 32768;
            endcase
            write_reg(CFG_SETPOINT, {4'b0, sp[SPEED_W-1:0]});
            case ($urandom_range(3))
                0: write_reg(CFG_GAIN_KP, 20'd0);
                1: write_reg(CFG_GAIN_KP, 20'd255);
                default: write_reg(CFG_GAIN_KP, 20'($urandom_range(255)));
            endcase
            if (ph == 3)
                write_reg(CFG_WINDOW, 20'hFFFFF);
            else if (ph == 5)
                write_reg(CFG_WINDOW, 20'd1);
            else
                write_reg(CFG_WINDOW, 20'($urandom_range(4)));
            case ($urandom_range(3))
                0: write_reg(CFG_SCALE, 20'd0);
                1: write_reg(CFG_SCALE, 20'hFFFF);
                default: write_reg(CFG_SCALE, 20'($urandom_range(1024)));
            endcase
            case ($urandom_range(4))
                0: write_reg(CFG_PERIOD, 20'd0);
                1: write_reg(CFG_PERIOD, 20'd255);
                2: write_reg(CFG_PERIOD, 20'd1);
                default: write_reg(CFG_PERIOD, 20'($urandom_range(40, 2)));
            endcase
            en_pct = (ph == 2) ? 30 : 90;
            n = (ph == 3) ? 20 : 55;
            for (i = 0; i < n; i++) begin
                r = $urandom_range(99);
                if (r < 3)
                    enc_dir = -enc_dir;
                if (r < 10) begin
                    // glitch: pins jump without moving the walker
                    a = 1'($urandom_range(1));
                    b = 1'($urandom_range(1));
                end else begin
                    if (r >= 25)
                        enc_q = (enc_q + enc_dir + 4) % 4;
                    a = (enc_q == 1 || enc_q == 2);
                    b = (enc_q == 2 || enc_q == 3);
                end
                en = ($urandom_range(99) < en_pct);
                send_tick(a, b, en, 1'b0, none);
            end
        end

        in_if.valid <= 1'b0;
        while (tick_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
